// ===== sv/i2cdws_pkg.sv =====
// Package: shared types and constants of the I2C DAC write sequencer.
`default_nettype none
package i2cdws_pkg;

    // Request codes on req_type
    localparam logic [1:0] REQ_TICK  = 2'd0;
    localparam logic [1:0] REQ_RANGE = 2'd1;
    localparam logic [1:0] REQ_DATA  = 2'd2;

    // Configuration register indexes
    localparam logic [1:0] CFG_DEV_ADDR   = 2'd0;
    localparam logic [1:0] CFG_RANGE_REG  = 2'd1;
    localparam logic [1:0] CFG_RANGE_VAL  = 2'd2;
    localparam logic [1:0] CFG_DATA_REG   = 2'd3;

    // Configuration reset values
    localparam logic [7:0] RST_DEV_ADDR  = 8'hb0;
    localparam logic [7:0] RST_RANGE_REG = 8'h01;
    localparam logic [7:0] RST_RANGE_VAL = 8'h77;
    localparam logic [7:0] RST_DATA_REG  = 8'h02;

    // Three ticks per bit: SCL low, high, low
    localparam logic [1:0] PH_LOW0 = 2'd0;
    localparam logic [1:0] PH_HIGH = 2'd1;
    localparam logic [1:0] PH_LOW1 = 2'd2;

    // Bit slot 8 of a byte is the acknowledge
    localparam logic [3:0] ACK_SLOT = 4'd8;

    // Last byte index of each transaction kind
    localparam logic [1:0] LAST_IDX_RANGE = 2'd2;
    localparam logic [1:0] LAST_IDX_DATA  = 2'd3;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_START,
        ST_BYTE,
        ST_STOP
    } t_state;

    typedef struct packed {
        logic [7:0] dev_addr;
        logic [7:0] range_reg;
        logic [7:0] range_val;
        logic [7:0] data_reg;
    } t_cfg;

    typedef struct packed {
        logic       scl;
        logic       sda_out;
        logic       sda_drive;
        logic       busy;
        logic       done;
        logic [3:0] ack_status;
        logic       rejected;
    } t_res;

endpackage
`default_nettype wire

// ===== sv/i2cdws_cfg.sv =====
// Configuration register file of the I2C DAC write sequencer.
`default_nettype none
module i2cdws_cfg
    import i2cdws_pkg::*;
(
    input  wire         i_clk,
    input  wire         i_rst_n,
    input  wire         i_wr_en,
    input  wire  [1:0]  i_index,
    input  wire  [7:0]  i_data,
    output t_cfg        o_cfg
);

    t_cfg r_cfg;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.dev_addr  <= RST_DEV_ADDR;
            r_cfg.range_reg <= RST_RANGE_REG;
            r_cfg.range_val <= RST_RANGE_VAL;
            r_cfg.data_reg  <= RST_DATA_REG;
        end else if (i_wr_en) begin
            unique case (i_index)
                CFG_DEV_ADDR:  r_cfg.dev_addr  <= i_data;
                CFG_RANGE_REG: r_cfg.range_reg <= i_data;
                CFG_RANGE_VAL: r_cfg.range_val <= i_data;
                CFG_DATA_REG:  r_cfg.data_reg  <= i_data;
                default:       r_cfg.dev_addr  <= r_cfg.dev_addr;
            endcase
        end
    end

    assign o_cfg = r_cfg;

endmodule
`default_nettype wire

// ===== sv/i2cdws_seq.sv =====
// Bus sequencer: start / byte / stop state machine, bit counters, ack record.
`default_nettype none
module i2cdws_seq
    import i2cdws_pkg::*;
(
    input  wire         i_clk,
    input  wire         i_rst_n,
    input  wire         i_fire,
    input  wire  [1:0]  i_req_type,
    input  wire  [15:0] i_dac_value,
    input  wire         i_sda_in,
    input  wire t_cfg   i_cfg,
    output t_res        o_res
);

    t_state      r_state, n_state, e_state;
    logic [1:0]  r_ph, n_ph;
    logic [3:0]  r_bit, n_bit;
    logic [1:0]  r_idx, n_idx;
    logic        r_data, n_data;
    logic [15:0] r_val, n_val;
    logic [3:0]  r_ack, n_ack;

    logic        w_req;
    logic        w_start;
    logic [1:0]  w_last_idx;
    logic [7:0]  w_byte;
    logic [2:0]  w_bit_sel;

    assign w_req   = (i_req_type == REQ_RANGE) || (i_req_type == REQ_DATA);
    assign w_start = (r_state == ST_IDLE) && w_req;
    assign e_state = w_start ? ST_START : r_state;

    // next state, counters, latched word and ack record
    always_comb begin
        n_state = e_state;
        n_ph    = r_ph;
        n_bit   = r_bit;
        n_idx   = r_idx;
        n_data  = r_data;
        n_val   = r_val;
        n_ack   = r_ack;
        if (w_start) begin
            n_data = (i_req_type == REQ_DATA);
            n_ack  = 4'd0;
            if (i_req_type == REQ_DATA) begin
                n_val = i_dac_value;
            end
        end
        w_last_idx = n_data ? LAST_IDX_DATA : LAST_IDX_RANGE;
        if (e_state != ST_IDLE) begin
            n_ph = (r_ph == PH_LOW1) ? PH_LOW0 : r_ph + 2'd1;
        end
        unique case (e_state)
            ST_IDLE: begin
                n_state = ST_IDLE;
            end
            ST_START: begin
                if (r_ph == PH_LOW1) begin
                    n_state = ST_BYTE;
                    n_bit   = 4'd0;
                    n_idx   = 2'd0;
                end
            end
            ST_BYTE: begin
                if (r_bit == ACK_SLOT && r_ph == PH_HIGH) begin
                    n_ack[r_idx] = i_sda_in;
                end
                if (r_ph == PH_LOW1) begin
                    if (r_bit == ACK_SLOT) begin
                        n_bit = 4'd0;
                        if (r_idx == w_last_idx) begin
                            n_state = ST_STOP;
                        end else begin
                            n_idx = r_idx + 2'd1;
                        end
                    end else begin
                        n_bit = r_bit + 4'd1;
                    end
                end
            end
            ST_STOP: begin
                if (r_ph == PH_LOW1) begin
                    n_state = ST_IDLE;
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    // byte on the wire
    always_comb begin
        case (r_idx)
            2'd0:    w_byte = i_cfg.dev_addr;
            2'd1:    w_byte = r_data ? i_cfg.data_reg : i_cfg.range_reg;
            2'd2:    w_byte = r_data ? r_val[7:0] : i_cfg.range_val;
            default: w_byte = r_val[15:8];
        endcase
    end

    assign w_bit_sel = 3'd7 - r_bit[2:0];

    // line levels and status of this tick
    always_comb begin
        o_res.scl        = 1'b0;
        o_res.sda_out    = 1'b1;
        o_res.sda_drive  = 1'b1;
        o_res.busy       = (e_state != ST_IDLE);
        o_res.done       = 1'b0;
        o_res.ack_status = n_ack;
        o_res.rejected   = (r_state != ST_IDLE) && w_req;
        unique case (e_state)
            ST_IDLE: begin
                o_res.scl = 1'b0;
            end
            ST_START: begin
                o_res.scl     = (r_ph != PH_LOW1);
                o_res.sda_out = (r_ph == PH_LOW0);
            end
            ST_BYTE: begin
                o_res.scl = (r_ph == PH_HIGH);
                if (r_bit == ACK_SLOT) begin
                    o_res.sda_out   = 1'b0;
                    o_res.sda_drive = 1'b0;
                end else begin
                    o_res.sda_out = w_byte[w_bit_sel];
                end
            end
            ST_STOP: begin
                o_res.scl     = (r_ph != PH_LOW0);
                o_res.sda_out = (r_ph == PH_LOW1);
                o_res.done    = (r_ph == PH_LOW1);
            end
            default: o_res.scl = 1'b0;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_ph    <= PH_LOW0;
            r_bit   <= 4'd0;
            r_idx   <= 2'd0;
            r_data  <= 1'b0;
            r_val   <= 16'd0;
            r_ack   <= 4'd0;
        end else if (i_fire) begin
            r_state <= n_state;
            r_ph    <= n_ph;
            r_bit   <= n_bit;
            r_idx   <= n_idx;
            r_data  <= n_data;
            r_val   <= n_val;
            r_ack   <= n_ack;
        end
    end

endmodule
`default_nettype wire

// ===== sv/i2c_dac_write_sequencer.sv =====
// Top level: I2C DAC write sequencer with input and result registers.
// Usage notes:
//  - Each input word is one bus tick (nominally 1 us). req_type selects a
//    plain tick, a range-select start or a data-write start; a start is only
//    taken while idle, otherwise the tick reports rejected and runs on.
//  - Every accepted word yields exactly one result word with the SCL/SDA
//    levels for that tick, busy, done, the ack record and rejected.
//  - Range select: start, 3 bytes, stop = 87 ticks. Data write: start,
//    4 bytes (address, register, value low, value high), stop = 114 ticks.
//  - Ack of each byte is sampled from sda_in on its SCL-high tick; a NACK is
//    recorded in ack_status and the transfer continues.
//  - Path: a word is held in the input register, runs through the sequencer
//    logic and is then held in the result register until it is taken.
//  - Throughput: one word per cycle unless out-stall holds the result; the
//    sequencer state advances once per word, one pass between the registers.
//  - Output stall holds the result register; the input register still takes
//    a word while the result waits, then in-stall rises until it drains.
//  - Config registers (index 0..3) are written via cfg_valid/cfg_ready, ready
//    is always high; write only while no transaction is in flight.
//  - Reset (synchronous, active low) empties both registers, returns the
//    sequencer to idle and loads the config reset values.
`default_nettype none
module i2c_dac_write_sequencer
    import i2cdws_pkg::*;
(
    input  wire         i_clk,
    input  wire         i_rst_n,

    input  wire         i_in_valid,
    output logic        o_in_stall,
    input  wire  [1:0]  i_req_type,
    input  wire  [15:0] i_dac_value,
    input  wire         i_sda_in,

    output logic        o_out_valid,
    input  wire         i_out_stall,
    output logic        o_scl,
    output logic        o_sda_out,
    output logic        o_sda_drive,
    output logic        o_busy_res,
    output logic        o_done_res,
    output logic [3:0]  o_ack_status,
    output logic        o_rejected,

    input  wire         i_cfg_valid,
    output logic        o_cfg_ready,
    input  wire  [1:0]  i_cfg_index,
    input  wire  [7:0]  i_cfg_data
);

    // input register
    logic        r_in_valid;
    logic [1:0]  r_req_type;
    logic [15:0] r_dac_value;
    logic        r_sda_in;

    // result register
    logic        r_out_valid;
    t_res        r_res;

    logic        w_fire;
    logic        w_in_take;
    t_cfg        w_cfg;
    t_res        w_res;

    // process the held word when the result slot is free or draining
    assign w_fire     = r_in_valid && (!r_out_valid || !i_out_stall);
    assign w_in_take  = !r_in_valid || w_fire;
    assign o_in_stall = !w_in_take;
    assign o_cfg_ready = 1'b1;

    i2cdws_cfg u_cfg (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_wr_en (i_cfg_valid),
        .i_index (i_cfg_index),
        .i_data  (i_cfg_data),
        .o_cfg   (w_cfg)
    );

    i2cdws_seq u_seq (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_fire      (w_fire),
        .i_req_type  (r_req_type),
        .i_dac_value (r_dac_value),
        .i_sda_in    (r_sda_in),
        .i_cfg       (w_cfg),
        .o_res       (w_res)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (w_in_take) begin
            r_in_valid <= i_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_in_take && i_in_valid) begin
            r_req_type  <= i_req_type;
            r_dac_value <= i_dac_value;
            r_sda_in    <= i_sda_in;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_fire) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_fire) begin
            r_res <= w_res;
        end
    end

    assign o_out_valid  = r_out_valid;
    assign o_scl        = r_res.scl;
    assign o_sda_out    = r_res.sda_out;
    assign o_sda_drive  = r_res.sda_drive;
    assign o_busy_res   = r_res.busy;
    assign o_done_res   = r_res.done;
    assign o_ack_status = r_res.ack_status;
    assign o_rejected   = r_res.rejected;

endmodule
`default_nettype wire

// ===== tb/sv/i2c_dac_write_sequencer_test.sv =====
// Testbench for the I2C DAC write sequencer: random bus ticks checked against a tick predictor.
`timescale 1ns / 100ps
module i2c_dac_write_sequencer_test
    import i2cdws_pkg::*;
();

    // Bus timing: every bit (and the ack) is three ticks, start and stop three ticks each
    localparam int PHASE_TICKS = 3;
    localparam int START_TICKS = 3;
    localparam int BYTE_TICKS  = 27;
    localparam int RANGE_TICKS = 87;
    localparam int DATA_TICKS  = 114;
    // Tick offset of the ack SCL-high slot inside one byte
    localparam int ACK_TICK    = 25;

    // req_type 3 is unused by the block: a plain tick, never rejected
    localparam logic [1:0] REQ_SPARE = 2'd3;

    localparam int LONG_HOLD      = 250;
    localparam int WATCHDOG_LIMIT = 3000;
    localparam int RANDOM_PHASES  = 4;
    localparam int PHASE_WORDS    = 150;

    typedef struct packed {
        logic [1:0]  req;
        logic [15:0] value;
        logic        sda;
    } t_tick_word;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        i_in_valid = 1'b0;
    logic [1:0]  i_req_type = REQ_TICK;
    logic [15:0] i_dac_value = '0;
    logic        i_sda_in = 1'b0;
    logic        i_out_stall = 1'b0;
    logic        i_cfg_valid = 1'b0;
    logic [1:0]  i_cfg_index = CFG_DEV_ADDR;
    logic [7:0]  i_cfg_data = '0;

    logic        o_in_stall;
    logic        o_out_valid;
    logic        o_scl;
    logic        o_sda_out;
    logic        o_sda_drive;
    logic        o_busy_res;
    logic        o_done_res;
    logic [3:0]  o_ack_status;
    logic        o_rejected;
    logic        o_cfg_ready;

    i2c_dac_write_sequencer DUT (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_in_valid   (i_in_valid),
        .o_in_stall   (o_in_stall),
        .i_req_type   (i_req_type),
        .i_dac_value  (i_dac_value),
        .i_sda_in     (i_sda_in),
        .o_out_valid  (o_out_valid),
        .i_out_stall  (i_out_stall),
        .o_scl        (o_scl),
        .o_sda_out    (o_sda_out),
        .o_sda_drive  (o_sda_drive),
        .o_busy_res   (o_busy_res),
        .o_done_res   (o_done_res),
        .o_ack_status (o_ack_status),
        .o_rejected   (o_rejected),
        .i_cfg_valid  (i_cfg_valid),
        .o_cfg_ready  (o_cfg_ready),
        .i_cfg_index  (i_cfg_index),
        .i_cfg_data   (i_cfg_data)
    );

    // Tick words waiting to be offered, and bus levels predicted for accepted words
    t_tick_word tick_backlog[$];
    t_res       predicted_lines[$];

    // Predictor copy of the block: configuration plus sequencer state
    t_cfg        cfg_now;
    logic [6:0]  seq_step = '0;
    logic [15:0] held_value = '0;
    logic        data_mode = 1'b0;
    logic [3:0]  ack_rec = '0;
    logic        in_txn = 1'b0;

    int mismatch_count = 0;
    int words_queued = 0;
    int ticks_seen = 0;
    int quiet_cycles = 0;

    // Sender and receiver pacing
    int         send_gap = 0;
    int         send_calm = 0;
    int         stall_left = 0;
    int         recv_calm = 0;
    int         hold_left = 0;
    int         long_holds = 0;
    int         hold_after = 0;
    t_tick_word next_tick;
    t_res       got_line;
    t_res       want_line;

    initial begin
        forever #4 i_clk = ~i_clk;
    end

    task automatic flag_mismatch(input string msg);
        if (mismatch_count < 100)
            $display("MISMATCH @%0t: %s", $time, msg);
        mismatch_count++;
    endtask

    task automatic check_field(input string name, input logic [3:0] got_v,
                               input logic [3:0] want_v);
        if (got_v !== want_v)
            flag_mismatch($sformatf("tick %0d %s: got %0h, expected %0h",
                                    ticks_seen, name, got_v, want_v));
    endtask

    // Byte sent in slot idx of the running transaction; registers are read live
    function automatic logic [7:0] byte_at(input int idx);
        case (idx)
            0:       return cfg_now.dev_addr;
            1:       return data_mode ? cfg_now.data_reg : cfg_now.range_reg;
            2:       return data_mode ? held_value[7:0] : cfg_now.range_val;
            default: return held_value[15:8];
        endcase
    endfunction

    // One bus tick: advance the predicted sequencer and return the line levels
    function automatic t_res predict_tick(input logic [1:0] req, input logic [15:0] val,
                                          input logic sda);
        t_res       r;
        logic       is_start;
        logic [7:0] cur;
        int         body, rel, idx, slot, ph, p;
        r = '0;
        r.sda_out = 1'b1;
        r.sda_drive = 1'b1;
        is_start = (req == REQ_RANGE) || (req == REQ_DATA);
        if (in_txn) begin
            r.rejected = is_start;
        end else if (is_start) begin
            in_txn = 1'b1;
            seq_step = '0;
            ack_rec = '0;
            data_mode = (req == REQ_DATA);
            if (data_mode)
                held_value = val;
        end
        if (in_txn) begin
            body = START_TICKS + (data_mode ? 4 : 3) * BYTE_TICKS;
            r.busy = 1'b1;
            if (seq_step < START_TICKS) begin
                // start: SDA falls under a high SCL, then SCL drops
                r.scl = (seq_step < 2);
                r.sda_out = (seq_step == 0);
            end else if (seq_step < body) begin
                rel = seq_step - START_TICKS;
                idx = rel / BYTE_TICKS;
                slot = (rel % BYTE_TICKS) / PHASE_TICKS;
                ph = (rel % BYTE_TICKS) % PHASE_TICKS;
                r.scl = (ph == PH_HIGH);
                if (slot < ACK_SLOT) begin
                    cur = byte_at(idx);
                    r.sda_out = cur[7 - slot];
                end else begin
                    // SDA released to the slave; the level field reads 0
                    r.sda_out = 1'b0;
                    r.sda_drive = 1'b0;
                    if (ph == PH_HIGH)
                        ack_rec[idx] = sda;
                end
            end else begin
                // stop: SCL rises with SDA low, then SDA rises
                p = seq_step - body;
                r.scl = (p >= 1);
                r.sda_out = (p >= 2);
                r.done = (p >= 2);
            end
            if (r.done) begin
                in_txn = 1'b0;
                seq_step = '0;
            end else begin
                seq_step = seq_step + 1'b1;
            end
        end
        r.ack_status = ack_rec;
        return r;
    endfunction

    // Mostly short gaps, a few long ones
    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 55)
            return 0;
        if (r < 88)
            return $urandom_range(1, 3);
        if (r < 97)
            return $urandom_range(4, 12);
        return $urandom_range(20, 60);
    endfunction

    function automatic logic [7:0] pick_byte();
        case ($urandom_range(0, 3))
            0:       return 8'h00;
            1:       return 8'hff;
            default: return 8'($urandom);
        endcase
    endfunction

    task automatic queue_tick(input logic [1:0] req, input logic [15:0] val, input logic sda);
        t_tick_word w;
        w.req = req;
        w.value = val;
        w.sda = sda;
        tick_backlog.push_back(w);
        words_queued++;
    endtask

    // Whole transaction: start word, then tick words with the ack level per byte
    // set from nack; noise_pct of the later words carry a stray request.
    task automatic queue_txn(input logic [1:0] kind, input logic [15:0] val,
                             input logic [3:0] nack, input int noise_pct);
        int         len;
        logic [1:0] req;
        logic       sda;
        len = (kind == REQ_DATA) ? DATA_TICKS : RANGE_TICKS;
        for (int s = 0; s < len; s++) begin
            req = REQ_TICK;
            sda = 1'($urandom);
            if (s == 0)
                req = kind;
            else if ($urandom_range(0, 99) < noise_pct)
                req = 2'($urandom_range(1, 3));
            if (s >= START_TICKS && (s - START_TICKS) % BYTE_TICKS == ACK_TICK)
                sda = nack[(s - START_TICKS) / BYTE_TICKS];
            queue_tick(req, (s == 0) ? val : 16'($urandom), sda);
        end
    endtask

    // Plain ticks only: no start can come of them
    task automatic queue_idle(input int n);
        for (int i = 0; i < n; i++)
            queue_tick($urandom_range(0, 1) ? REQ_SPARE : REQ_TICK, 16'($urandom),
                       1'($urandom));
    endtask

    // Unshaped words: starts, rejects and stray selectors at random
    task automatic queue_noise(input int n);
        for (int i = 0; i < n; i++)
            queue_tick(2'($urandom), 16'($urandom), 1'($urandom));
    endtask

    task automatic drain_words();
        do
            @(negedge i_clk);
        while (tick_backlog.size() != 0 || i_in_valid || predicted_lines.size() != 0);
    endtask

    // Let everything come back, then run out any transaction still going so
    // the sequencer is idle before the next register writes.
    task automatic end_phase();
        drain_words();
        if (in_txn) begin
            queue_idle((data_mode ? DATA_TICKS : RANGE_TICKS) - seq_step);
            drain_words();
        end
    endtask

    task automatic write_reg(input logic [1:0] idx, input logic [7:0] data);
        @(posedge i_clk);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data <= data;
        do
            @(posedge i_clk);
        while (!o_cfg_ready);
        i_cfg_valid <= 1'b0;
        case (idx)
            CFG_DEV_ADDR:  cfg_now.dev_addr = data;
            CFG_RANGE_REG: cfg_now.range_reg = data;
            CFG_RANGE_VAL: cfg_now.range_val = data;
            CFG_DATA_REG:  cfg_now.data_reg = data;
        endcase
    endtask

    task automatic set_config(input logic [7:0] dev, input logic [7:0] rreg,
                              input logic [7:0] rval, input logic [7:0] dreg);
        write_reg(CFG_DEV_ADDR, dev);
        write_reg(CFG_RANGE_REG, rreg);
        write_reg(CFG_RANGE_VAL, rval);
        write_reg(CFG_DATA_REG, dreg);
    endtask

    // Driver: predict each accepted word, then offer the next one after its gap.
    // A word held by in-stall keeps valid and payload unchanged.
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_in_valid <= 1'b0;
            send_gap <= 0;
        end else begin
            if (i_in_valid && !o_in_stall) begin
                predicted_lines.push_back(predict_tick(i_req_type, i_dac_value, i_sda_in));
            end
            if (!i_in_valid || !o_in_stall) begin
                if (send_gap > 0) begin
                    i_in_valid <= 1'b0;
                    send_gap <= send_gap - 1;
                end else if (tick_backlog.size() != 0) begin
                    next_tick = tick_backlog.pop_front();
                    i_in_valid <= 1'b1;
                    i_req_type <= next_tick.req;
                    i_dac_value <= next_tick.value;
                    i_sda_in <= next_tick.sda;
                    // calm stretches send back to back
                    if (send_calm > 0) begin
                        send_calm--;
                        send_gap <= 0;
                    end else begin
                        send_gap <= pick_gap();
                        if ($urandom_range(0, 59) == 0)
                            send_calm = $urandom_range(40, 160);
                    end
                end else begin
                    i_in_valid <= 1'b0;
                end
            end
        end
    end

    // Monitor: compare each result word with the oldest prediction, and pace
    // out-stall. Up to twice, while plenty of words are queued, it holds off for a
    // long stretch so both registers fill and in-stall rises.
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_out_stall <= 1'b0;
        end else begin
            if (o_out_valid && !i_out_stall) begin
                got_line.scl = o_scl;
                got_line.sda_out = o_sda_out;
                got_line.sda_drive = o_sda_drive;
                got_line.busy = o_busy_res;
                got_line.done = o_done_res;
                got_line.ack_status = o_ack_status;
                got_line.rejected = o_rejected;
                if (predicted_lines.size() == 0) begin
                    flag_mismatch($sformatf("result word %0d with nothing expected",
                                            ticks_seen));
                end else begin
                    want_line = predicted_lines.pop_front();
                    check_field("scl", got_line.scl, want_line.scl);
                    check_field("sda_out", got_line.sda_out, want_line.sda_out);
                    check_field("sda_drive", got_line.sda_drive, want_line.sda_drive);
                    check_field("busy", got_line.busy, want_line.busy);
                    check_field("done", got_line.done, want_line.done);
                    check_field("ack_status", got_line.ack_status, want_line.ack_status);
                    check_field("rejected", got_line.rejected, want_line.rejected);
                end
                ticks_seen++;
            end
            if (hold_left > 0) begin
                i_out_stall <= 1'b1;
                hold_left--;
            end else if (long_holds < 2 && tick_backlog.size() > 150 &&
                         ticks_seen >= hold_after) begin
                i_out_stall <= 1'b1;
                hold_left = LONG_HOLD;
                long_holds++;
                hold_after = ticks_seen + 300;
            end else if (stall_left > 0) begin
                i_out_stall <= 1'b1;
                stall_left--;
            end else begin
                i_out_stall <= 1'b0;
                if (recv_calm > 0) begin
                    recv_calm--;
                end else begin
                    stall_left = pick_gap();
                    if ($urandom_range(0, 59) == 0)
                        recv_calm = $urandom_range(40, 160);
                end
            end
        end
    end

    // Watchdog: too long without any word moving on any channel
    always @(posedge i_clk) begin
        if ((i_in_valid && !o_in_stall) || (o_out_valid && !i_out_stall) ||
            (i_cfg_valid && o_cfg_ready)) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles == WATCHDOG_LIMIT) begin
            $display("i2c_dac_write_sequencer_test: errors");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    initial begin
        int target;
        cfg_now.dev_addr = RST_DEV_ADDR;
        cfg_now.range_reg = RST_RANGE_REG;
        cfg_now.range_val = RST_RANGE_VAL;
        cfg_now.data_reg = RST_DATA_REG;
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Reset configuration: idle lines, full ack, all-NACK, stray requests
        // mid-transfer, back-to-back transfers, ack record held while idle.
        // The range select with every NACK set keeps bit 3 clear.
        queue_idle(4);
        queue_txn(REQ_RANGE, 16'h0000, 4'b0000, 0);
        queue_txn(REQ_DATA, 16'hffff, 4'b1111, 0);
        queue_idle(3);
        queue_txn(REQ_DATA, 16'h0000, 4'b0101, 25);
        queue_txn(REQ_RANGE, 16'($urandom), 4'b1111, 25);
        queue_idle(5);
        end_phase();

        // Register extremes
        set_config(8'h00, 8'h00, 8'h00, 8'h00);
        queue_txn(REQ_DATA, 16'h8001, 4'b0000, 0);
        queue_txn(REQ_RANGE, 16'h0000, 4'b1010, 0);
        queue_idle(2);
        end_phase();

        set_config(8'hff, 8'hff, 8'hff, 8'hff);
        queue_txn(REQ_DATA, 16'h7ffe, 4'b0110, 10);
        queue_txn(REQ_RANGE, 16'hffff, 4'b0000, 10);
        queue_idle(2);
        end_phase();

        // Random phases: mostly whole transactions with random content,
        // the rest idle ticks and unshaped words
        for (int ph = 0; ph < RANDOM_PHASES; ph++) begin
            if (ph == 0)
                set_config(RST_DEV_ADDR, RST_RANGE_REG, RST_RANGE_VAL, RST_DATA_REG);
            else
                set_config(pick_byte(), pick_byte(), pick_byte(), pick_byte());
            target = words_queued + PHASE_WORDS;
            while (words_queued < target) begin
                case ($urandom_range(0, 9))
                    8:       queue_idle($urandom_range(1, 8));
                    9:       queue_noise($urandom_range(3, 25));
                    default: queue_txn($urandom_range(0, 1) ? REQ_DATA : REQ_RANGE,
                                       16'($urandom),
                                       ($urandom_range(0, 3) == 0) ? 4'($urandom) : 4'b0000,
                                       $urandom_range(0, 5));
                endcase
            end
            end_phase();
        end

        // Pipeline is two registers deep; give stray words time to show
        repeat (8) @(posedge i_clk);
        if (predicted_lines.size() != 0)
            flag_mismatch($sformatf("%0d predicted words never came",
                                    predicted_lines.size()));
        if (mismatch_count == 0)
            $display("i2c_dac_write_sequencer_test: clean");
        else
            $display("i2c_dac_write_sequencer_test: errors");
        $finish;
    end

endmodule
